// File: design/swms_pkg.sv
// Shared types and constants for the shortest window minimum spread block.
package swms_pkg;
  localparam int POINT_DEPTH = 1024;
  localparam int COORD_BITS = 20;
  localparam int IDX_W = $clog2(POINT_DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int IN_BYTES_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_BYTES_W = ((COORD_BITS + 2 + 7) / 8) * 8;

  typedef struct packed {
    logic                  last_point;
    logic [COORD_BITS-1:0] val_y;
    logic [COORD_BITS-1:0] pos_x;
  } item_t;

  typedef struct packed {
    logic [PTR_W-1:0]      seq;
    logic [COORD_BITS-1:0] y;
  } qent_t;

  localparam int QENT_W = $bits(qent_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OVF_RD,
    ST_OVF_CHK,
    ST_WRITE,
    ST_MAX_RD,
    ST_MAX_CHK,
    ST_MIN_RD,
    ST_MIN_CHK,
    ST_SHR_RD,
    ST_SHR_CHK,
    ST_DONE
  } st_t;
endpackage

// File: design/swms_ram.sv
// Generic single write port, single registered read port RAM.
module swms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/swms_front.sv
// Front end: accepts point requests and queues them for the back end.
module swms_front
  import swms_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);
  item_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               push;
  logic               pop;

  assign in_ready = count != (FIFO_AW + 1)'(FIFO_DEPTH);
  assign q_valid = count != '0;
  assign q_item = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// File: design/swms_back.sv
// Back end: window buffer, monotonic queues and the shrink sequencer.
module swms_back
  import swms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_best,
  output logic                  out_found,
  output logic                  out_overflow,
  output logic                  out_last
);
  st_t state;
  st_t state_next;

  logic [COORD_BITS-1:0] min_spread;
  logic [PTR_W-1:0] max_head, max_tail, min_head, min_tail;
  logic [PTR_W-1:0] left_index, right_index;
  logic [PTR_W-1:0] cur_seq;
  logic [COORD_BITS-1:0] best_so_far;
  logic found_flag;
  logic overflow_flag;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic cur_last;

  logic x_we;
  logic [COORD_BITS-1:0] x_rdata;
  logic max_we, min_we;
  logic [IDX_W-1:0] max_raddr, min_raddr;
  qent_t max_rdata, min_rdata;
  qent_t push_ent;

  logic [PTR_W-1:0] live;
  logic max_empty, min_empty;
  logic max_pop_hit, min_pop_hit;
  logic [COORD_BITS-1:0] spread;
  logic [COORD_BITS-1:0] width;
  logic shrink_ok;

  assign live = right_index - left_index;
  assign max_empty = max_tail == max_head;
  assign min_empty = min_tail == min_head;
  assign max_pop_hit = cur_y >= max_rdata.y;
  assign min_pop_hit = cur_y <= min_rdata.y;
  assign spread = (max_rdata.y >= min_rdata.y) ? max_rdata.y - min_rdata.y : '0;
  assign width = (cur_x >= x_rdata) ? cur_x - x_rdata : '0;
  assign shrink_ok = spread >= min_spread;
  assign push_ent = '{seq: cur_seq, y: cur_y};

  swms_ram #(.WIDTH(COORD_BITS), .DEPTH(POINT_DEPTH)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(right_index[IDX_W-1:0]), .wdata(cur_x),
    .raddr(left_index[IDX_W-1:0]), .rdata(x_rdata)
  );

  swms_ram #(.WIDTH(QENT_W), .DEPTH(POINT_DEPTH)) u_max_ram (
    .clk(clk), .we(max_we), .waddr(max_tail[IDX_W-1:0]), .wdata(push_ent),
    .raddr(max_raddr), .rdata(max_rdata)
  );

  swms_ram #(.WIDTH(QENT_W), .DEPTH(POINT_DEPTH)) u_min_ram (
    .clk(clk), .we(min_we), .waddr(min_tail[IDX_W-1:0]), .wdata(push_ent),
    .raddr(min_raddr), .rdata(min_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (live >= PTR_W'(POINT_DEPTH)) ? ST_OVF_RD : ST_WRITE;
        end
      end
      ST_OVF_RD: state_next = ST_OVF_CHK;
      ST_OVF_CHK: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_MAX_RD;
      ST_MAX_RD: state_next = max_empty ? ST_MIN_RD : ST_MAX_CHK;
      ST_MAX_CHK: state_next = max_pop_hit ? ST_MAX_RD : ST_MIN_RD;
      ST_MIN_RD: state_next = min_empty ? ST_SHR_RD : ST_MIN_CHK;
      ST_MIN_CHK: state_next = min_pop_hit ? ST_MIN_RD : ST_SHR_RD;
      ST_SHR_RD: begin
        if (max_empty || min_empty || live == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHR_CHK;
        end
      end
      ST_SHR_CHK: state_next = shrink_ok ? ST_SHR_RD : ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = state == ST_IDLE && q_valid;
    x_we = state == ST_WRITE;
    max_we = (state == ST_MAX_RD && max_empty) || (state == ST_MAX_CHK && !max_pop_hit);
    min_we = (state == ST_MIN_RD && min_empty) || (state == ST_MIN_CHK && !min_pop_hit);
    max_raddr = (state == ST_MAX_RD) ? IDX_W'(max_tail - 1'b1) : max_head[IDX_W-1:0];
    min_raddr = (state == ST_MIN_RD) ? IDX_W'(min_tail - 1'b1) : min_head[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_spread <= COORD_BITS'(1);
    end else if (cfg_we) begin
      min_spread <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur_x <= q_item.pos_x;
      cur_y <= q_item.val_y;
      cur_last <= q_item.last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      max_head <= '0;
      max_tail <= '0;
      min_head <= '0;
      min_tail <= '0;
      left_index <= '0;
      right_index <= '0;
      cur_seq <= '0;
      best_so_far <= '1;
      found_flag <= 1'b0;
      overflow_flag <= 1'b0;
      out_valid <= 1'b0;
      out_best <= '0;
      out_found <= 1'b0;
      out_overflow <= 1'b0;
      out_last <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_OVF_CHK: begin
          left_index <= left_index + 1'b1;
          overflow_flag <= 1'b1;
          if (!max_empty && max_rdata.seq == left_index) begin
            max_head <= max_head + 1'b1;
          end
          if (!min_empty && min_rdata.seq == left_index) begin
            min_head <= min_head + 1'b1;
          end
        end
        ST_WRITE: begin
          cur_seq <= right_index;
          right_index <= right_index + 1'b1;
        end
        ST_MAX_RD: begin
          if (max_empty) begin
            max_tail <= max_tail + 1'b1;
          end
        end
        ST_MAX_CHK: begin
          max_tail <= max_pop_hit ? max_tail - 1'b1 : max_tail + 1'b1;
        end
        ST_MIN_RD: begin
          if (min_empty) begin
            min_tail <= min_tail + 1'b1;
          end
        end
        ST_MIN_CHK: begin
          min_tail <= min_pop_hit ? min_tail - 1'b1 : min_tail + 1'b1;
        end
        ST_SHR_CHK: begin
          if (shrink_ok) begin
            if (!found_flag || width < best_so_far) begin
              best_so_far <= width;
            end
            found_flag <= 1'b1;
            left_index <= left_index + 1'b1;
            if (max_rdata.seq == left_index) begin
              max_head <= max_head + 1'b1;
            end
            if (min_rdata.seq == left_index) begin
              min_head <= min_head + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_best <= found_flag ? best_so_far : '0;
            out_found <= found_flag;
            out_overflow <= overflow_flag;
            out_last <= cur_last;
            if (cur_last) begin
              max_head <= '0;
              max_tail <= '0;
              min_head <= '0;
              min_tail <= '0;
              left_index <= '0;
              right_index <= '0;
              best_so_far <= '1;
              found_flag <= 1'b0;
              overflow_flag <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= PTR_W'(POINT_DEPTH))
    else $error("window holds more points than the buffer");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    PTR_W'(max_tail - max_head) <= PTR_W'(POINT_DEPTH))
    else $error("maximum queue longer than the buffer");

  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    PTR_W'(min_tail - min_head) <= PTR_W'(POINT_DEPTH))
    else $error("minimum queue longer than the buffer");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && cur_last && (!out_valid || out_ready))
      |=> (right_index == '0 && !found_flag && !overflow_flag))
    else $error("state not cleared after the last point of a set");
`endif
endmodule

// File: design/shortest_window_min_spread.sv
// Top level of the shortest window minimum spread block.
// Points arrive as requests on the s_ channel in nondecreasing x order; each
// request yields exactly one result request on the m_ channel. s_tlast marks
// the final point of a set, and m_tlast marks the result for that point.
// Each point is written to the window buffer (dropping the oldest point when
// the window is full), pushed onto the maximum and minimum queues after
// removing the tail entries it dominates, and then the window is shrunk from
// the left while its spread is at least min_spread. Each step waits on one
// registered read of the window and queue RAMs. Each point enters and leaves
// each queue at most once and is shrunk out only once. A four-entry request
// queue lets the sender run ahead while a point is busy. The result sits in
// an output register, so the next point is processed while the receiver
// stalls; the sequencer waits only if that register is still full when the
// next result is ready. cfg_we must write min_spread only while the block is
// idle; the block itself does not enforce this. Reset sets min_spread to 1 and
// clears the window, best width and flags. No clearing pass is needed.
module shortest_window_min_spread
  import swms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_BYTES_W-1:0]  s_tdata,   // pos_x, val_y
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_BYTES_W-1:0] m_tdata,   // best_width, found, overflow, zero pad
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [COORD_BITS-1:0]  cfg_wdata
);
  item_t in_item;
  item_t q_item;
  logic q_valid;
  logic q_pop;
  logic [COORD_BITS-1:0] out_best;
  logic out_found;
  logic out_overflow;

  assign in_item = '{last_point: s_tlast,
                     val_y: s_tdata[2*COORD_BITS-1:COORD_BITS],
                     pos_x: s_tdata[COORD_BITS-1:0]};

  assign m_tdata = OUT_BYTES_W'({out_overflow, out_found, out_best});

  swms_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  swms_back u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_best(out_best), .out_found(out_found),
    .out_overflow(out_overflow), .out_last(m_tlast)
  );
endmodule

// File: tb/sv/swms_checker.sv
// Checker that predicts the shortest window minimum spread results and compares them.
module swms_checker
  import swms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_BYTES_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_BYTES_W-1:0] m_tdata,
  input  logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [COORD_BITS-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen
);
  typedef struct packed {
    logic [COORD_BITS-1:0] best_width;
    logic                  found;
    logic                  overflow;
    logic                  set_done;
  } window_result_t;

  localparam int EXP_DEPTH = 64;

  logic [COORD_BITS-1:0] spread_req;
  logic [COORD_BITS-1:0] win_x [POINT_DEPTH];
  logic [COORD_BITS-1:0] win_y [POINT_DEPTH];
  int unsigned hi_q [POINT_DEPTH];
  int unsigned lo_q [POINT_DEPTH];
  int unsigned hi_head, hi_tail, lo_head, lo_tail;
  int unsigned left_seq, right_seq;
  logic [COORD_BITS-1:0] best_w;
  logic found_w, ovf_w;
  window_result_t exp_buf [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int fails = 0;
  int results_cnt = 0;

  assign pending = exp_wr - exp_rd;
  assign fail_count = fails;
  assign results_seen = results_cnt;

  task automatic clear_window();
    hi_head = 0;
    hi_tail = 0;
    lo_head = 0;
    lo_tail = 0;
    left_seq = 0;
    right_seq = 0;
    best_w = '1;
    found_w = 0;
    ovf_w = 0;
  endtask

  task automatic drop_oldest();
    if (hi_tail != hi_head && hi_q[hi_head % POINT_DEPTH] == left_seq) hi_head++;
    if (lo_tail != lo_head && lo_q[lo_head % POINT_DEPTH] == left_seq) lo_head++;
    left_seq++;
  endtask

  task automatic predict_window(input item_t pt);
    window_result_t r;
    logic [COORD_BITS-1:0] hi, lo, xl, w;
    int unsigned seq;
    if (right_seq - left_seq >= POINT_DEPTH) begin
      drop_oldest();
      ovf_w = 1;
    end
    seq = right_seq;
    win_x[seq % POINT_DEPTH] = pt.pos_x;
    win_y[seq % POINT_DEPTH] = pt.val_y;
    right_seq++;
    while (hi_tail != hi_head &&
           pt.val_y >= win_y[hi_q[(hi_tail - 1) % POINT_DEPTH] % POINT_DEPTH]) hi_tail--;
    hi_q[hi_tail % POINT_DEPTH] = seq;
    hi_tail++;
    while (lo_tail != lo_head &&
           pt.val_y <= win_y[lo_q[(lo_tail - 1) % POINT_DEPTH] % POINT_DEPTH]) lo_tail--;
    lo_q[lo_tail % POINT_DEPTH] = seq;
    lo_tail++;
    while (hi_tail != hi_head && lo_tail != lo_head && right_seq != left_seq) begin
      hi = win_y[hi_q[hi_head % POINT_DEPTH] % POINT_DEPTH];
      lo = win_y[lo_q[lo_head % POINT_DEPTH] % POINT_DEPTH];
      if ((hi >= lo ? hi - lo : '0) < spread_req) break;
      xl = win_x[left_seq % POINT_DEPTH];
      w = pt.pos_x >= xl ? pt.pos_x - xl : '0;
      if (!found_w || w < best_w) best_w = w;
      found_w = 1;
      drop_oldest();
    end
    r.best_width = found_w ? best_w : '0;
    r.found = found_w;
    r.overflow = ovf_w;
    r.set_done = pt.last_point;
    exp_buf[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
    if (pt.last_point) clear_window();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    window_result_t e;
    item_t pt;
    if (rst) begin
      spread_req = COORD_BITS'(1);
      clear_window();
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (cfg_we) spread_req = cfg_wdata;
      if (s_tvalid && s_tready) begin
        pt.pos_x = s_tdata[COORD_BITS-1:0];
        pt.val_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
        pt.last_point = s_tlast;
        predict_window(pt);
      end
      if (m_tvalid && m_tready) begin
        results_cnt++;
        if (exp_wr == exp_rd) begin
          report_mismatch("unexpected result", 32'(m_tdata), '0);
        end else begin
          e = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (m_tdata[COORD_BITS-1:0] !== e.best_width)
            report_mismatch("best_width", 32'(m_tdata[COORD_BITS-1:0]), 32'(e.best_width));
          if (m_tdata[COORD_BITS] !== e.found)
            report_mismatch("found", 32'(m_tdata[COORD_BITS]), 32'(e.found));
          if (m_tdata[COORD_BITS+1] !== e.overflow)
            report_mismatch("overflow", 32'(m_tdata[COORD_BITS+1]), 32'(e.overflow));
          if (m_tlast !== e.set_done)
            report_mismatch("set_done", 32'(m_tlast), 32'(e.set_done));
        end
      end
    end
  end
endmodule

// File: tb/sv/testbench.sv
// Stimulus and verdict for the shortest window minimum spread block.
module testbench;
  import swms_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_BYTES_W-1:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_BYTES_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 0;
  logic [COORD_BITS-1:0] cfg_wdata = '0;
  int fail_count, pending, results_seen;
  int send_idle_pct, recv_idle_pct;
  int points_sent;
  logic [COORD_BITS-1:0] cur_x;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  shortest_window_min_spread u_top (.*);
  swms_checker u_chk (.*);

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_point(input int x, input int y, input int last);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= IN_BYTES_W'({COORD_BITS'(y), COORD_BITS'(x)});
    s_tlast <= (last != 0);
    rdy = s_tready;
    @(posedge clk);
    while (!rdy) begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end
    @(negedge clk);
    points_sent++;
  endtask

  task automatic set_spread(input int v);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= COORD_BITS'(v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_set(input int n, input int y_bits, input int x_step);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) cur_x = COORD_BITS'($urandom);
      else if (i > 0 || $urandom_range(1) == 1)
        cur_x = cur_x + COORD_BITS'($urandom_range(x_step));
      else cur_x = COORD_BITS'($urandom_range(1000));
      send_point(int'(cur_x), int'($urandom & ((1 << y_bits) - 1)), int'(i == n - 1));
    end
  endtask

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 74;
    points_sent = 0;
    cur_x = 0;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_point(0, 0, 0);
    send_point(0, '1, 0);
    send_point('1, 0, 0);
    send_point('1, '1, 1);
    send_point(5, 7, 1);
    send_point(100, 10, 0);
    send_point(50, 20, 0);
    send_point(200, 20, 1);
    set_spread('1);
    send_point(10, 0, 0);
    send_point(30, '1, 0);
    send_point(31, 3, 1);
    set_spread(0);
    send_point(1, 4, 0);
    send_point(3, 4, 0);
    send_point(9, 9, 1);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 74;
        recv_idle_pct = 16;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_spread(ph == 0 ? 100 : ph == 1 ? $urandom_range(1, 1 << 19) : 1);
      for (int s = 0; s < 29; s++)
        random_set($urandom_range(1, 16), $urandom_range(20) == 0 ? 1 : $urandom_range(4, 20),
                   $urandom_range(1) ? 50 : 1 << 19);
    end
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d points in several spread settings, checked %0d results.",
             points_sent, results_seen);
    if (fail_count == 0) $display("shortest_window_min_spread test passed");
    else $display("shortest_window_min_spread test failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("shortest_window_min_spread test failed");
    $finish;
  end
endmodule

// File: shortest_window_min_spread.f
design/swms_pkg.sv
design/swms_ram.sv
design/swms_front.sv
design/swms_back.sv
design/shortest_window_min_spread.sv
tb/sv/swms_checker.sv
tb/sv/testbench.sv
